// ===== hw/rtl/nce_pkg.sv =====
// nce_pkg: shared types and constants for the nonzero coordinate extractor
// no dependencies; imported by nce_odometer and nonzero_coordinate_extractor_top

package nce_pkg;

   localparam int NUM_DIMS    = 6;
   localparam int COORD_W     = 16;
   localparam int COUNT_W     = 31;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int RANK_W      = 3;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 128;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COND_TYPE = 3'd0,
      CSR_RANK      = 3'd1,
      CSR_DIM_0     = 3'd2,
      CSR_DIM_1     = 3'd3,
      CSR_DIM_2     = 3'd4,
      CSR_DIM_3     = 3'd5,
      CSR_DIM_4     = 3'd6,
      CSR_DIM_5     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      COND_INT32   = 2'd0,
      COND_FLOAT32 = 2'd1,
      COND_BOOL    = 2'd2
   } cond_kind_type;

   typedef logic [NUM_DIMS-1:0][COORD_W-1:0] dim_arr_type;

   // control from the input stage to the odometer
   typedef struct packed {
      logic step;
      logic hit;
      logic last;
   } step_ctrl_type;

endpackage

// ===== hw/rtl/nonzero_coordinate_extractor_top.sv =====
// nonzero_coordinate_extractor_top: input register, truth test, odometer, result register
// depends on nce_pkg and nce_odometer
//
// Usage: condition elements enter on the req_ channel in row-major order, one request
// per element, with req_tlast on the final element of the tensor. Each true element
// gives one result on the rsp_ channel carrying its coordinates and the running true
// count; the last element always gives a result (rsp_tlast high) with the final
// saturating count, and a false last element reports rsp_tuser low and zero coords.
// False elements that are not last give no result.
// Shape and element type are set through the csr_ write port while the block is idle;
// register index 0 is the element type, 1 the rank, 2 to 7 the dimension sizes.
// A request is first captured in the input register; the truth test and odometer then
// load its result into the result register, which drives rsp_.
// Throughput: one request per cycle while the receiver does not stall; the odometer carry
// chain and the truth test are combinational between input register and result register.
// When the receiver stalls, the result register holds and the input register fills;
// req_tready then falls until the held result is taken, even if the element waiting
// in the input register needs no result.
// Synchronous reset clears both valid flags, the odometer and the count, and loads
// the register defaults: int32 elements, rank 1, every dimension size 1.

module nonzero_coordinate_extractor_top #(
   parameter int MAX_RANK = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [nce_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [nce_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [nce_pkg::REQ_DATA_W-1:0]         req_tdata,  // cond_value
   input  logic                                   req_tlast,  // last_elem
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // coord_0..coord_5 at [95:0], true_count at [126:96], zero pad at [127]
   output logic [nce_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tuser,  // hit
   output logic                                   rsp_tlast   // done_res
);
   import nce_pkg::*;

   localparam logic [RANK_W-1:0] RankCap = RANK_W'(MAX_RANK);

   // configuration registers
   logic [1:0]        cond_type_ff;
   logic [RANK_W-1:0] rank_ff;
   dim_arr_type       dims_ff;

   // input register
   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  in_last_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   dim_arr_type           rsp_coords_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  rsp_hit_ff;
   logic                  rsp_last_ff;

   logic                  hit;
   logic                  advance;
   logic                  load_rsp;
   logic [RANK_W-1:0]     rank_use;
   step_ctrl_type         ctrl;
   dim_arr_type           coords;
   logic [COUNT_W-1:0]    count_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         cond_type_ff <= COND_INT32;
         rank_ff      <= RANK_W'(1);
         dims_ff      <= {NUM_DIMS{COORD_W'(1)}};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COND_TYPE: cond_type_ff <= csr_wdata[1:0];
            CSR_RANK:      rank_ff      <= csr_wdata[RANK_W-1:0];
            CSR_DIM_0:     dims_ff[0]   <= csr_wdata;
            CSR_DIM_1:     dims_ff[1]   <= csr_wdata;
            CSR_DIM_2:     dims_ff[2]   <= csr_wdata;
            CSR_DIM_3:     dims_ff[3]   <= csr_wdata;
            CSR_DIM_4:     dims_ff[4]   <= csr_wdata;
            CSR_DIM_5:     dims_ff[5]   <= csr_wdata;
            default:       ;
         endcase
      end
   end

   assign rank_use = (rank_ff > RankCap) ? RankCap : rank_ff;

   // float is true unless +/-0; the unused code reads like int32
   always_comb begin
      case (cond_type_ff)
         COND_FLOAT32: hit = (in_data_ff[30:0] != '0);
         COND_BOOL:    hit = (in_data_ff[7:0] != '0);
         default:      hit = (in_data_ff != '0);
      endcase
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign load_rsp   = in_valid_ff && advance && (hit || in_last_ff);

   assign ctrl.step = in_valid_ff && advance;
   assign ctrl.hit  = hit;
   assign ctrl.last = in_last_ff;

   nce_odometer #(
      .MAX_RANK (MAX_RANK)
   ) u_odometer (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .rank_use   (rank_use),
      .dims       (dims_ff),
      .coords     (coords),
      .count_next (count_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_coords_ff <= coords;
         rsp_count_ff  <= count_next;
         rsp_hit_ff    <= hit;
         rsp_last_ff   <= in_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_coords_ff};
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // a result for a false element only comes from the last element
   a_miss_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_last_ff)
      else $error("false element result without done");
   // a false element reports zero coordinates
   a_miss_zero_coords : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> (rsp_coords_ff == '0))
      else $error("false element result with nonzero coords");
   // a true element has been counted
   a_hit_counted : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> (rsp_count_ff != '0))
      else $error("true element result with zero count");
   // an empty result register never blocks requests
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request blocked with result register empty");
`endif

endmodule

// ===== hw/rtl/nce_odometer.sv =====
// nce_odometer: row-major position counter and saturating true count
// depends on nce_pkg

module nce_odometer #(
   parameter int MAX_RANK = 6
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  nce_pkg::step_ctrl_type                  ctrl,
   input  logic [nce_pkg::RANK_W-1:0]              rank_use,
   input  nce_pkg::dim_arr_type                    dims,
   output nce_pkg::dim_arr_type                    coords,
   output logic [nce_pkg::COUNT_W-1:0]             count_next
);
   import nce_pkg::*;

   logic [MAX_RANK-1:0][COORD_W-1:0] pos_ff;
   logic [MAX_RANK-1:0][COORD_W-1:0] pos_in;
   logic [COUNT_W-1:0]               count_ff;
   logic [COUNT_W-1:0]               count_in;

   // carry ripples from the innermost digit in use outward
   always_comb begin
      logic carry;
      logic wrap;
      carry  = 1'b1;
      wrap   = 1'b0;
      pos_in = pos_ff;
      for (int k = MAX_RANK - 1; k >= 0; k--) begin
         if (RANK_W'(k) < rank_use) begin
            wrap = ({1'b0, pos_ff[k]} + (COORD_W+1)'(1)) >= {1'b0, dims[k]};
            if (carry) begin
               pos_in[k] = wrap ? '0 : pos_ff[k] + COORD_W'(1);
            end
            carry = carry & wrap;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.hit && (count_ff != {COUNT_W{1'b1}})) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   assign count_next = count_in;

   always_comb begin
      coords = '0;
      for (int k = 0; k < MAX_RANK; k++) begin
         if (ctrl.hit && (RANK_W'(k) < rank_use)) begin
            coords[k] = pos_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
      end else if (ctrl.step) begin
         if (ctrl.last) begin
            pos_ff   <= '0;
            count_ff <= '0;
         end else begin
            pos_ff   <= pos_in;
            count_ff <= count_in;
         end
      end
   end

`ifndef SYNTH
   // the count only moves on a step
   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      !ctrl.step |=> $stable(count_ff))
      else $error("true count changed without a step");
   // a last element always leaves a clean scan
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      ctrl.step && ctrl.last |=> (count_ff == '0) && (pos_ff == '0))
      else $error("scan not cleared after last element");
   // count never decreases except on the clear
   a_count_mono : assert property (@(posedge clock) disable iff (reset)
      ctrl.step && !ctrl.last |=> count_ff >= $past(count_ff))
      else $error("true count went backward");
`endif

endmodule
